// ===== rtl/core/sem_pkg.sv =====
// ----------------------------------------------------------------------------
// sem_pkg: shared types and constants of the sobel edge magnitude block
// Payload structs of the three channels, register indexes, fixed field widths
// and the register clamp helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package sem_pkg;

  localparam int PIX_W     = 8;
  localparam int COL_W     = 10;
  localparam int ROW_W     = 12;
  localparam int COLS_W    = 11;
  localparam int ROWS_W    = 13;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_VAL_W = 16;

  localparam logic [COLS_W-1:0] COLS_RESET = 11'd640;
  localparam logic [ROWS_W-1:0] ROWS_RESET = 13'd480;
  localparam logic [COLS_W-1:0] COLS_MIN   = 11'd3;
  localparam logic [ROWS_W-1:0] ROWS_MIN   = 13'd3;
  localparam logic [ROWS_W-1:0] ROWS_MAX   = 13'd4096;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLUMNS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS    = 4'd1;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic             frame_start;
  } pix_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] edge_value;
    logic [ROW_W-1:0] center_row;
    logic [COL_W-1:0] center_column;
    logic             frame_end;
  } res_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_VAL_W-1:0] value;
  } cfg_item_t;

  function automatic logic [COLS_W-1:0] clamp_cols(input logic [COLS_W-1:0] v,
                                                   input logic [COLS_W-1:0] hi);
    logic [COLS_W-1:0] c;
    c = v;
    if (c > hi) c = hi;
    if (c < COLS_MIN) c = COLS_MIN;
    return c;
  endfunction

  function automatic logic [ROWS_W-1:0] clamp_rows(input logic [ROWS_W-1:0] v);
    logic [ROWS_W-1:0] r;
    r = v;
    if (r > ROWS_MAX) r = ROWS_MAX;
    if (r < ROWS_MIN) r = ROWS_MIN;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sem_stream_if.sv =====
// ----------------------------------------------------------------------------
// sem_stream_if: valid/ready channel
// One item moves at a clock edge with valid and ready both high; the payload
// type is set per instance.
// ----------------------------------------------------------------------------
`default_nettype none

interface sem_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// ===== rtl/core/sem_cell.sv =====
// ----------------------------------------------------------------------------
// sem_cell: one pixel cell of the window chain
// Holds one pixel and takes its right neighbor's pixel on every shift.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     shift,
  input  logic [sem_pkg::PIX_W-1:0] d,
  output logic [sem_pkg::PIX_W-1:0] q
);

  logic [sem_pkg::PIX_W-1:0] pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_r <= '0;
    end else if (shift) begin
      pix_r <= d;
    end
  end

  assign q = pix_r;

endmodule

`default_nettype wire

// ===== rtl/core/sem_line_ram.sv =====
// ----------------------------------------------------------------------------
// sem_line_ram: line store
// One write port and one read port with registered, enabled read data;
// a read at the written address returns the old entry.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_line_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [sem_pkg::PIX_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [sem_pkg::PIX_W-1:0] rd_data
);

  logic [sem_pkg::PIX_W-1:0] mem [DEPTH];
  logic [sem_pkg::PIX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/core/sem_magnitude.sv =====
// ----------------------------------------------------------------------------
// sem_magnitude: sobel gradient magnitude
// Vertical and horizontal 1-2-1 gradients of the 3x3 window, each clamped to
// 255, summed and clamped again.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_magnitude (
  input  logic [8:0][sem_pkg::PIX_W-1:0] win,
  output logic [sem_pkg::PIX_W-1:0]      edge_value
);

  logic [9:0] top_sum, bot_sum, lef_sum, rig_sum;
  logic [9:0] gv_abs, gh_abs;
  logic [7:0] gv_sat, gh_sat;
  logic [8:0] mag_sum;

  // index r*3+c, r 0 top row, c 0 left column
  always_comb begin
    top_sum = {2'b00, win[0]} + {1'b0, win[1], 1'b0} + {2'b00, win[2]};
    bot_sum = {2'b00, win[6]} + {1'b0, win[7], 1'b0} + {2'b00, win[8]};
    lef_sum = {2'b00, win[0]} + {1'b0, win[3], 1'b0} + {2'b00, win[6]};
    rig_sum = {2'b00, win[2]} + {1'b0, win[5], 1'b0} + {2'b00, win[8]};
    gv_abs  = (top_sum > bot_sum) ? (top_sum - bot_sum) : (bot_sum - top_sum);
    gh_abs  = (lef_sum > rig_sum) ? (lef_sum - rig_sum) : (rig_sum - lef_sum);
    gv_sat  = (|gv_abs[9:8]) ? 8'hFF : gv_abs[7:0];
    gh_sat  = (|gh_abs[9:8]) ? 8'hFF : gh_abs[7:0];
    mag_sum = {1'b0, gv_sat} + {1'b0, gh_sat};
    edge_value = mag_sum[8] ? 8'hFF : mag_sum[7:0];
  end

endmodule

`default_nettype wire

// ===== rtl/core/sobel_edge_magnitude.sv =====
// ----------------------------------------------------------------------------
// sobel_edge_magnitude: 3x3 sobel edge magnitude on a raster pixel stream
// Two line stores feed a chain of nine window cells; interior pixels give
// a saturated edge magnitude with the center pixel's coordinates.
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                                             accept
//  in_s     in   pixel_value, frame_start                            valid & ready
//  out_s    out  edge_value, center_row, center_column, frame_end    valid & ready
//  cfg_s    in   index, value (0 image_columns, 1 image_rows)        valid & ready
//
//  one item per cycle sustained while out_s is ready; a result goes through the
//  line store read, window shift and magnitude stages to the output register
//  the line store read port and the window shift set that pace
//  rst_n clears position, window and stage valids and resets the config
//  registers; line stores are not cleared and need no pass after reset
//  a stalled output holds only the stage it blocks: pixels keep entering while
//  the window stage is free, and cfg_s is always ready
//
`default_nettype none

module sobel_edge_magnitude #(
  parameter int MAX_LINE_WIDTH = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  sem_stream_if.sink   in_s,
  sem_stream_if.source out_s,
  sem_stream_if.sink   cfg_s
);

  localparam int LINE_DEPTH = (MAX_LINE_WIDTH < 1024) ? MAX_LINE_WIDTH : 1024;
  localparam int AW         = $clog2(LINE_DEPTH);
  localparam logic [sem_pkg::COLS_W-1:0] COLS_HI = sem_pkg::COLS_W'(LINE_DEPTH);

  localparam int PW = sem_pkg::PIX_W;
  localparam int CW = sem_pkg::COL_W;
  localparam int RW = sem_pkg::ROW_W;

  // configuration, stored already clamped
  logic [sem_pkg::COLS_W-1:0] cols_used_r;
  logic [sem_pkg::ROWS_W-1:0] rows_used_r;

  assign cfg_s.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_used_r <= sem_pkg::clamp_cols(sem_pkg::COLS_RESET, COLS_HI);
      rows_used_r <= sem_pkg::clamp_rows(sem_pkg::ROWS_RESET);
    end else if (cfg_s.valid && cfg_s.ready) begin
      unique case (cfg_s.data.index)
        sem_pkg::REG_IMAGE_COLUMNS: begin
          cols_used_r <= sem_pkg::clamp_cols(cfg_s.data.value[sem_pkg::COLS_W-1:0],
                                             COLS_HI);
        end
        sem_pkg::REG_IMAGE_ROWS: begin
          rows_used_r <= sem_pkg::clamp_rows(cfg_s.data.value[sem_pkg::ROWS_W-1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  // handshake and stage flow
  logic accept, s1_go, s2_go;
  logic s1_valid_r, s2_valid_r, out_valid_r;

  assign s2_go       = s2_valid_r && (!out_valid_r || out_s.ready);
  assign s1_go       = s1_valid_r && (!s2_valid_r || s2_go);
  assign in_s.ready  = !s1_valid_r || s1_go;
  assign accept      = in_s.valid && in_s.ready;

  // raster position
  logic [CW-1:0] col_r, col_nxt, cur_col;
  logic [RW-1:0] row_r, row_nxt, cur_row;
  logic [AW-1:0] cur_addr;
  logic          row_end, frame_last, interior;

  always_comb begin
    cur_col    = in_s.data.frame_start ? '0 : col_r;
    cur_row    = in_s.data.frame_start ? '0 : row_r;
    cur_addr   = cur_col[AW-1:0];
    row_end    = (({1'b0, cur_col} + 11'd1) >= cols_used_r);
    frame_last = row_end && (({1'b0, cur_row} + 13'd1) >= rows_used_r);
    interior   = (cur_row >= 12'd2) && (cur_col >= 10'd2);
    if (row_end) begin
      col_nxt = '0;
      row_nxt = frame_last ? '0 : cur_row + 12'd1;
    end else begin
      col_nxt = cur_col + 10'd1;
      row_nxt = cur_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // stage 1: pixel waiting for its line store data
  logic [PW-1:0] s1_pix_r, byp_pix_r;
  logic [CW-1:0] s1_col_r;
  logic [RW-1:0] s1_row_r;
  logic          s1_int_r, s1_last_r, byp_r;
  logic          byp_hit;
  logic [PW-1:0] up_q, mid_q, up_src;

  // the upper store takes the stage 1 item's middle entry at the same edge that
  // a new item may read that column (back to back frame starts)
  assign byp_hit = s1_valid_r && (s1_col_r[AW-1:0] == cur_addr);
  assign up_src  = byp_r ? byp_pix_r : up_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r  <= in_s.data.pixel_value;
      s1_col_r  <= cur_col;
      s1_row_r  <= cur_row;
      s1_int_r  <= interior;
      s1_last_r <= frame_last;
      byp_r     <= byp_hit;
      byp_pix_r <= mid_q;
    end
  end

  sem_line_ram #(
    .DEPTH (LINE_DEPTH),
    .AW    (AW)
  ) u_upper (
    .clk     (clk),
    .wr_en   (s1_go),
    .wr_addr (s1_col_r[AW-1:0]),
    .wr_data (mid_q),
    .rd_en   (accept),
    .rd_addr (cur_addr),
    .rd_data (up_q)
  );

  sem_line_ram #(
    .DEPTH (LINE_DEPTH),
    .AW    (AW)
  ) u_middle (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (cur_addr),
    .wr_data (in_s.data.pixel_value),
    .rd_en   (accept),
    .rd_addr (cur_addr),
    .rd_data (mid_q)
  );

  // window: three rows of three cells, shifting left as each pixel goes by
  logic [8:0][PW-1:0] win;
  logic [2:0][PW-1:0] win_src;

  assign win_src[0] = up_src;
  assign win_src[1] = mid_q;
  assign win_src[2] = s1_pix_r;

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      logic [PW-1:0] cell_d;

      if (c == 2) begin : g_feed
        assign cell_d = win_src[r];
      end else begin : g_pass
        assign cell_d = win[r*3+c+1];
      end

      sem_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (s1_go),
        .d     (cell_d),
        .q     (win[r*3+c])
      );
    end
  end

  // stage 2: window holds an interior pixel's neighborhood
  logic [CW-1:0] s2_col_r;
  logic [RW-1:0] s2_row_r;
  logic          s2_last_r;
  logic [PW-1:0] edge_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_go) begin
      s2_valid_r <= s1_int_r;
    end else if (s2_go) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_col_r  <= s1_col_r - 10'd1;
      s2_row_r  <= s1_row_r - 12'd1;
      s2_last_r <= s1_last_r;
    end
  end

  sem_magnitude u_mag (
    .win        (win),
    .edge_value (edge_value)
  );

  // output register
  sem_pkg::res_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_go) begin
      out_valid_r <= 1'b1;
    end else if (out_s.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      out_data_r.edge_value    <= edge_value;
      out_data_r.center_row    <= s2_row_r;
      out_data_r.center_column <= s2_col_r;
      out_data_r.frame_end     <= s2_last_r;
    end
  end

  assign out_s.valid = out_valid_r;
  assign out_s.data  = out_data_r;

  // checks
  a_bypass_on_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && byp_hit) |-> in_s.data.frame_start)
    else $error("line store bypass without a frame start");

  a_interior_reaches_window: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_int_r) |=> s2_valid_r)
    else $error("interior pixel lost between stages");

  a_column_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, col_r} < 11'(LINE_DEPTH)))
    else $error("column position beyond line store");

  a_center_not_border: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.center_row != '0) && (out_data_r.center_column != '0))
    else $error("result on a border pixel");

endmodule

`default_nettype wire
